// ===== rtl/core/wls_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wls_pkg: shared types and constants of the weighted lottery scheduler
// Controller states, command/status bundles, result codes and register map.
// ----------------------------------------------------------------------------
package wls_pkg;

    // Fixed field widths of the item interface
    localparam int SLOT_BITS     = 6;
    localparam int CFG_BITS      = 8;
    localparam int RAND_BITS     = 31;
    localparam int DIV_CNT_BITS  = 5;
    localparam int STATUS_BITS   = 2;
    localparam int CFG_IDX_BITS  = 1;

    // Table entries addressable by the slot field
    localparam int SLOT_SPAN     = 2 ** SLOT_BITS;

    // Result status codes
    localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_RANGE = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_MIN_WEIGHT = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_WEIGHT = 1'b1;

    // Reset values of the configuration registers
    localparam logic [CFG_BITS-1:0] MIN_WEIGHT_RST = 8'd1;
    localparam logic [CFG_BITS-1:0] MAX_WEIGHT_RST = 8'd100;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SUM,
        ST_CHECK,
        ST_DIV,
        ST_PICK,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        RES_UPD_OK,
        RES_RANGE,
        RES_EMPTY,
        RES_GRANT
    } res_kind_t;

    // Controller -> datapath
    typedef struct packed {
        logic      load_in;
        logic      do_update;
        logic      scan_clear;
        logic      scan_step;
        logic      div_start;
        logic      div_step;
        logic      load_out;
        res_kind_t res_kind;
    } ctrl_cmd_t;

    // Datapath -> controller
    typedef struct packed {
        logic func_draw;
        logic weight_ok;
        logic scan_last;
        logic sum_zero;
        logic div_last;
        logic hit;
    } ctrl_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/wls_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wls_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module wls_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/wls_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wls_datapath: slot table, scan accumulator and remainder unit
// Holds the configuration bounds, the slot RAM with its valid bits, the
// weight scan, the bit-serial remainder and the result register.
// ----------------------------------------------------------------------------
module wls_datapath #(
    parameter int SLOTS       = 64,
    parameter int WEIGHT_BITS = 8
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // configuration writes
    input  wire logic                         cfg_we,
    input  wire logic [wls_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [wls_pkg::CFG_BITS-1:0] cfg_data,
    // input item fields
    input  wire logic                         func,
    input  wire logic [wls_pkg::SLOT_BITS-1:0] slot,
    input  wire logic                         runnable,
    input  wire logic [wls_pkg::CFG_BITS-1:0] weight,
    input  wire logic [wls_pkg::RAND_BITS-1:0] random_value,
    // controller interface
    input  wire wls_pkg::ctrl_cmd_t           cmd,
    output wls_pkg::ctrl_status_t             sts,
    // result payload
    output logic [wls_pkg::STATUS_BITS-1:0]   status,
    output logic                              winner_valid,
    output logic [wls_pkg::SLOT_BITS-1:0]     winner_slot
);

    import wls_pkg::*;

    // Only slots reachable by the slot field are stored; the rest stay zero
    localparam int MEM_DEPTH = (SLOTS < SLOT_SPAN) ? SLOTS : SLOT_SPAN;
    localparam int ADDR_BITS = $clog2(MEM_DEPTH);
    localparam int CNT_BITS  = $clog2(MEM_DEPTH + 1);
    localparam int SUM_BITS  = WEIGHT_BITS + ADDR_BITS;
    localparam int ENT_BITS  = WEIGHT_BITS + 1;

    // Configuration bounds
    logic [CFG_BITS-1:0] min_weight_reg;
    logic [CFG_BITS-1:0] max_weight_reg;

    // Latched item
    logic                 func_reg;
    logic [SLOT_BITS-1:0] slot_reg;
    logic                 run_reg;
    logic [CFG_BITS-1:0]  weight_reg;

    // Random value held from the accepted item
    logic [RAND_BITS-1:0] random_value_hold;

    // Table
    logic [MEM_DEPTH-1:0] valid_reg;
    logic                 ram_we;
    logic [ADDR_BITS-1:0] ram_waddr;
    logic [ENT_BITS-1:0]  ram_wdata;
    logic                 ram_re;
    logic [ADDR_BITS-1:0] ram_raddr;
    logic [ENT_BITS-1:0]  ram_rdata;

    // Scan
    logic [CNT_BITS-1:0]  idx_reg;
    logic                 issue;
    logic                 pend_reg;
    logic [ADDR_BITS-1:0] pend_idx_reg;
    logic                 vld_q_reg;
    logic [WEIGHT_BITS-1:0] eff_weight;
    logic [SUM_BITS-1:0]  acc_reg;
    logic [SUM_BITS-1:0]  acc_next;
    logic [ADDR_BITS-1:0] win_reg;

    // Remainder unit
    logic [SUM_BITS-1:0]     divisor_reg;
    logic [SUM_BITS-1:0]     rem_reg;
    logic [RAND_BITS-1:0]    rnd_sh_reg;
    logic [DIV_CNT_BITS-1:0] div_cnt_reg;
    logic [SUM_BITS:0]       rem_sh;
    logic                    rem_ge;

    logic weight_ok;
    logic slot_in_table;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_weight_reg <= MIN_WEIGHT_RST;
            max_weight_reg <= MAX_WEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MIN_WEIGHT: min_weight_reg <= cfg_data;
                CFG_MAX_WEIGHT: max_weight_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            func_reg   <= func;
            slot_reg   <= slot;
            run_reg    <= runnable;
            weight_reg <= weight;
        end
    end

    assign weight_ok     = (weight_reg >= min_weight_reg) && (weight_reg <= max_weight_reg);
    assign slot_in_table = (32'(slot_reg) < 32'(MEM_DEPTH));

    // Table write on an accepted update
    assign ram_we    = cmd.do_update && weight_ok && slot_in_table;
    assign ram_waddr = slot_reg[ADDR_BITS-1:0];
    assign ram_wdata = {run_reg, WEIGHT_BITS'(weight_reg)};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (ram_we)
        begin
            valid_reg[ram_waddr] <= 1'b1;
        end
    end

    // Scan read side
    assign issue     = (32'(idx_reg) < 32'(MEM_DEPTH));
    assign ram_re    = cmd.scan_step && issue;
    assign ram_raddr = idx_reg[ADDR_BITS-1:0];

    wls_ram #(
        .WIDTH (ENT_BITS),
        .DEPTH (MEM_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Unwritten or idle slots count as zero tickets
    assign eff_weight = (vld_q_reg && ram_rdata[WEIGHT_BITS]) ?
                        ram_rdata[WEIGHT_BITS-1:0] : '0;
    assign acc_next   = acc_reg + SUM_BITS'(eff_weight);

    // Scan counter, read pipeline and running sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            pend_reg <= 1'b0;
        end
        else if (cmd.scan_clear)
        begin
            idx_reg  <= '0;
            pend_reg <= 1'b0;
        end
        else if (cmd.scan_step)
        begin
            if (issue)
            begin
                idx_reg <= idx_reg + CNT_BITS'(1);
            end
            pend_reg <= issue;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scan_clear)
        begin
            acc_reg <= '0;
        end
        else if (cmd.scan_step)
        begin
            pend_idx_reg <= ram_raddr;
            vld_q_reg    <= valid_reg[ram_raddr];
            if (pend_reg)
            begin
                acc_reg <= acc_next;
            end
            if (sts.hit)
            begin
                win_reg <= pend_idx_reg;
            end
        end
    end

    // Bit-serial remainder: one dividend bit per step
    assign rem_sh = {rem_reg, rnd_sh_reg[RAND_BITS-1]};
    assign rem_ge = (rem_sh >= {1'b0, divisor_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            divisor_reg <= acc_reg;
            rem_reg     <= '0;
            rnd_sh_reg  <= random_value_hold;
            div_cnt_reg <= DIV_CNT_BITS'(RAND_BITS - 1);
        end
        else if (cmd.div_step)
        begin
            rem_reg     <= rem_ge ? SUM_BITS'(rem_sh - {1'b0, divisor_reg})
                                  : SUM_BITS'(rem_sh);
            rnd_sh_reg  <= {rnd_sh_reg[RAND_BITS-2:0], 1'b0};
            div_cnt_reg <= div_cnt_reg - DIV_CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            random_value_hold <= random_value;
        end
    end

    // Status to controller
    always_comb
    begin
        sts.func_draw = func_reg;
        sts.weight_ok = weight_ok;
        sts.scan_last = pend_reg && (pend_idx_reg == ADDR_BITS'(MEM_DEPTH - 1));
        sts.sum_zero  = (acc_reg == '0);
        sts.div_last  = (div_cnt_reg == '0);
        sts.hit       = pend_reg && (acc_next > rem_reg);
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            case (cmd.res_kind)
                RES_UPD_OK:
                begin
                    status       <= STATUS_OK;
                    winner_valid <= 1'b0;
                    winner_slot  <= '0;
                end
                RES_RANGE:
                begin
                    status       <= STATUS_RANGE;
                    winner_valid <= 1'b0;
                    winner_slot  <= '0;
                end
                RES_GRANT:
                begin
                    status       <= STATUS_OK;
                    winner_valid <= 1'b1;
                    winner_slot  <= SLOT_BITS'(win_reg);
                end
                default:
                begin
                    status       <= STATUS_EMPTY;
                    winner_valid <= 1'b0;
                    winner_slot  <= '0;
                end
            endcase
        end
    end

    // Remainder stays below the divisor while the unit iterates
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |-> (rem_reg < divisor_reg))
        else $error("remainder not below divisor");

    // A grant only follows a pick scan that has gathered tickets
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.load_out && (cmd.res_kind == RES_GRANT)) |-> !sts.sum_zero)
        else $error("grant without a scanned slot");

endmodule
`default_nettype wire

// ===== rtl/core/wls_controller.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wls_controller: sequencing state machine of the lottery scheduler
// Steps update transactions through the table write and draw transactions
// through sum scan, remainder and pick scan, and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module wls_controller (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output wls_pkg::ctrl_cmd_t        cmd,
    input  wire wls_pkg::ctrl_status_t sts
);

    import wls_pkg::*;

    state_t    state_reg;
    state_t    state_next;
    res_kind_t res_kind_reg;
    res_kind_t res_kind_next;
    logic      out_valid_reg;
    logic      out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    // State and result-kind registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            res_kind_reg <= RES_UPD_OK;
        end
        else
        begin
            state_reg    <= state_next;
            res_kind_reg <= res_kind_next;
        end
    end

    // Output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next    = state_reg;
        res_kind_next = res_kind_reg;
        in_ready      = 1'b0;
        cmd           = '0;
        cmd.res_kind  = res_kind_reg;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_START;
                end
            end
            ST_START:
            begin
                if (sts.func_draw)
                begin
                    cmd.scan_clear = 1'b1;
                    state_next     = ST_SUM;
                end
                else
                begin
                    cmd.do_update = 1'b1;
                    res_kind_next = sts.weight_ok ? RES_UPD_OK : RES_RANGE;
                    state_next    = ST_DONE;
                end
            end
            ST_SUM:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_last)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sts.sum_zero)
                begin
                    res_kind_next = RES_EMPTY;
                    state_next    = ST_DONE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    cmd.scan_clear = 1'b1;
                    state_next     = ST_PICK;
                end
            end
            ST_PICK:
            begin
                cmd.scan_step = 1'b1;
                if (sts.hit)
                begin
                    res_kind_next = RES_GRANT;
                    state_next    = ST_DONE;
                end
                else if (sts.scan_last)
                begin
                    res_kind_next = RES_EMPTY;
                    state_next    = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result register is never overwritten while a result is pending
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> out_free)
        else $error("result overwritten before it was taken");

    // Remainder unit hands over straight to the pick scan
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && sts.div_last) |=> (state_reg == ST_PICK))
        else $error("pick scan did not follow the remainder");

endmodule
`default_nettype wire

// ===== rtl/core/weighted_lottery_scheduler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_lottery_scheduler: lottery arbiter over a slot table
// Update transactions write a slot's runnable flag and ticket weight; draw
// transactions pick a runnable slot with probability set by its weight.
// ----------------------------------------------------------------------------
// One transaction is processed at a time; the next is accepted while a
// finished result still waits in the output register. An update passes
// through the start and done states and loads its result once the output
// register is free. A draw scans the slot table twice through the single
// read port of the slot RAM and reduces random_value modulo the ticket
// sum one bit per cycle; the pick scan stops at the winner, and a draw
// ends after the sum scan when no slot is runnable. After reset the
// table reads as all slots idle with zero weight; no clearing pass is
// needed. Configuration writes are always accepted and must only be issued
// while the block is idle.
// ----------------------------------------------------------------------------
module weighted_lottery_scheduler #(
    parameter int SLOTS       = 64,
    parameter int WEIGHT_BITS = 8
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // item input
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             func,
    input  wire logic [wls_pkg::SLOT_BITS-1:0]    slot,
    input  wire logic                             runnable,
    input  wire logic [wls_pkg::CFG_BITS-1:0]     weight,
    input  wire logic [wls_pkg::RAND_BITS-1:0]    random_value,
    // result output
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [wls_pkg::STATUS_BITS-1:0]       status,
    output logic                                  winner_valid,
    output logic [wls_pkg::SLOT_BITS-1:0]         winner_slot,
    // configuration writes
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [wls_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  wire logic [wls_pkg::CFG_BITS-1:0]     cfg_data
);

    import wls_pkg::*;

    ctrl_cmd_t    cmd;
    ctrl_status_t sts;

    // Bounds registers take a write in any cycle
    assign cfg_ready = 1'b1;

    wls_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    wls_datapath #(
        .SLOTS       (SLOTS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .func         (func),
        .slot         (slot),
        .runnable     (runnable),
        .weight       (weight),
        .random_value (random_value),
        .cmd          (cmd),
        .sts          (sts),
        .status       (status),
        .winner_valid (winner_valid),
        .winner_slot  (winner_slot)
    );

endmodule
`default_nettype wire
